[src/pcg4d_pkg.sv]
// Package for the pcg4d hash block: hash constants, stage counts and the
// per-stage record types. No dependencies.
package pcg4d_pkg;

   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam int unsigned XS_SHIFT = 16;

   localparam int unsigned LANES      = 4;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned HASH_W     = 33;
   // LCG step, four cross multiply-adds, xor-shift plus first add, three more adds
   localparam int unsigned MIX_STAGES = 9;
   // mix stages, then product, quotient and output stages
   localparam int unsigned PIPE_DEPTH = MIX_STAGES + 3;

   localparam int unsigned REQ_DATA_W = 192;
   localparam int unsigned RSP_DATA_W = 136;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic                     ranged;
      logic signed [WORD_W-1:0] lo;
      logic signed [WORD_W-1:0] hi;
      logic                     neg;   // span below zero
      logic                     full;  // span equals 2^32
      word_type                 mag;   // magnitude of span, low 32 bits
      word_type                 a;
      word_type                 b;
      word_type                 c;
      word_type                 d;
   } mix_type;

   typedef struct packed {
      logic                     ranged;
      logic signed [WORD_W-1:0] lo;
      logic signed [WORD_W-1:0] hi;
      logic                     neg;
      logic                     full;
      word_type [LANES-1:0]     h;
      logic [LANES-1:0][2*WORD_W-1:0] prod;
   } prod_type;

   typedef struct packed {
      logic                     ranged;
      logic signed [WORD_W-1:0] lo;
      logic signed [WORD_W-1:0] hi;
      word_type [LANES-1:0]     h;
      logic [LANES-1:0][WORD_W+1:0] q;  // signed floor quotient
   } quot_type;

   function automatic word_type xor_shift(input word_type v);
      xor_shift = v ^ (v >> XS_SHIFT);
   endfunction

endpackage

[src/pcg4d_hash_range_map_top.sv]
// Top level of the pcg4d hash range map block: a 12-stage pipeline with
// one cross multiply per stage in stages 1 to 8. Depends on pcg4d_pkg.
//
// Throughput: one item per cycle while rsp_tready is high; the chain of eight dependent
// cross multiply-adds sets the depth, with one 32x32 multiplier row per stage.
// Stalls: each stage holds its item while the stage after it is full and blocked,
// so bubbles close up and req_tready stays high while any stage is empty.
// Reset (synchronous, active high) empties every stage; payload is not cleared.
module pcg4d_hash_range_map_top
   import pcg4d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // coord_x, coord_y, coord_z, coord_w, range_low, range_high (low bit up)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hash_x, hash_y, hash_z, hash_w (33 bits each, low bit up), 4 zero pad bits
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned PROD_IDX = MIX_STAGES;
   localparam int unsigned QUOT_IDX = MIX_STAGES + 1;
   localparam int unsigned OUT_IDX  = MIX_STAGES + 2;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] advance;

   mix_type mix_ff [MIX_STAGES];
   mix_type mix_in [MIX_STAGES];
   prod_type prod_ff, prod_in;
   quot_type quot_ff, quot_in;
   logic [LANES-1:0][HASH_W-1:0] hash_ff, hash_in;

   // Field views of the incoming item
   word_type                 coord [LANES];
   logic signed [WORD_W-1:0] range_low;
   logic signed [WORD_W-1:0] range_high;
   logic signed [WORD_W+1:0] span;

   assign coord[0]   = req_tdata[31:0];
   assign coord[1]   = req_tdata[63:32];
   assign coord[2]   = req_tdata[95:64];
   assign coord[3]   = req_tdata[127:96];
   assign range_low  = req_tdata[159:128];
   assign range_high = req_tdata[191:160];

   // Span of the range: hi - lo + 1, in [-(2^32-2), 2^32]
   assign span = 34'(range_high) - 34'(range_low) + 34'sd1;

   // A stage takes a new item when it is empty or its item moves on
   always_comb begin
      advance[OUT_IDX] = !valid_ff[OUT_IDX] || rsp_tready;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   assign req_tready = advance[0];

   always_comb begin
      valid_in[0] = req_tvalid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   // Stage 0: LCG step on each word, range span setup.
   // Stages 1..8: one dependent cross multiply-add each; stage 5 also
   // applies the xor-shift to all four words before its add
   always_comb begin
      mix_in[0].ranged = req_tuser;
      mix_in[0].lo     = range_low;
      mix_in[0].hi     = range_high;
      mix_in[0].neg    = span[WORD_W+1];
      mix_in[0].full   = !span[WORD_W+1] && span[WORD_W];
      mix_in[0].mag    = span[WORD_W+1] ? WORD_W'(-span) : span[WORD_W-1:0];
      mix_in[0].a      = WORD_W'(coord[0] * LCG_MUL) + LCG_ADD;
      mix_in[0].b      = WORD_W'(coord[1] * LCG_MUL) + LCG_ADD;
      mix_in[0].c      = WORD_W'(coord[2] * LCG_MUL) + LCG_ADD;
      mix_in[0].d      = WORD_W'(coord[3] * LCG_MUL) + LCG_ADD;
      for (int i = 1; i < MIX_STAGES; i++) begin
         mix_in[i] = mix_ff[i-1];
         case (i)
            1: begin
               mix_in[i].a = mix_ff[i-1].a + WORD_W'(mix_ff[i-1].b * mix_ff[i-1].d);
            end
            2, 6: begin
               mix_in[i].b = mix_ff[i-1].b + WORD_W'(mix_ff[i-1].c * mix_ff[i-1].a);
            end
            3, 7: begin
               mix_in[i].c = mix_ff[i-1].c + WORD_W'(mix_ff[i-1].a * mix_ff[i-1].b);
            end
            4, 8: begin
               mix_in[i].d = mix_ff[i-1].d + WORD_W'(mix_ff[i-1].b * mix_ff[i-1].c);
            end
            5: begin
               mix_in[i].b = xor_shift(mix_ff[i-1].b);
               mix_in[i].c = xor_shift(mix_ff[i-1].c);
               mix_in[i].d = xor_shift(mix_ff[i-1].d);
               mix_in[i].a = xor_shift(mix_ff[i-1].a)
                  + WORD_W'(xor_shift(mix_ff[i-1].b) * xor_shift(mix_ff[i-1].d));
            end
            default: begin
               mix_in[i] = mix_ff[i-1];
            end
         endcase
      end
   end

   // Product stage: span magnitude times each hash word
   always_comb begin
      word_type h3;
      h3 = mix_ff[MIX_STAGES-1].d;
      prod_in.ranged = mix_ff[MIX_STAGES-1].ranged;
      prod_in.lo     = mix_ff[MIX_STAGES-1].lo;
      prod_in.hi     = mix_ff[MIX_STAGES-1].hi;
      prod_in.neg    = mix_ff[MIX_STAGES-1].neg;
      prod_in.full   = mix_ff[MIX_STAGES-1].full;
      prod_in.h[0]   = mix_ff[MIX_STAGES-1].a;
      prod_in.h[1]   = mix_ff[MIX_STAGES-1].b;
      prod_in.h[2]   = mix_ff[MIX_STAGES-1].c;
      prod_in.h[3]   = h3;
      for (int k = 0; k < LANES; k++) begin
         prod_in.prod[k] = 64'(mix_ff[MIX_STAGES-1].mag) * 64'(prod_in.h[k]);
      end
   end

   // Quotient stage: floor of span*h/2^32, rounding toward minus infinity
   always_comb begin
      logic [WORD_W:0] up;
      up = '0;
      quot_in.ranged = prod_ff.ranged;
      quot_in.lo     = prod_ff.lo;
      quot_in.hi     = prod_ff.hi;
      quot_in.h      = prod_ff.h;
      for (int k = 0; k < LANES; k++) begin
         up = {1'b0, prod_ff.prod[k][2*WORD_W-1:WORD_W]}
            + (WORD_W+1)'(prod_ff.prod[k][WORD_W-1:0] != '0);
         if (prod_ff.full) begin
            quot_in.q[k] = {2'b00, prod_ff.h[k]};
         end else if (prod_ff.neg) begin
            quot_in.q[k] = (WORD_W+2)'(-{1'b0, up});
         end else begin
            quot_in.q[k] = {2'b00, prod_ff.prod[k][2*WORD_W-1:WORD_W]};
         end
      end
   end

   // Output stage: add the lower bound, cap at the upper bound, or pass raw
   always_comb begin
      logic signed [WORD_W+1:0] r;
      logic signed [WORD_W+1:0] hi_ext;
      r      = '0;
      hi_ext = (WORD_W+2)'(quot_ff.hi);
      for (int k = 0; k < LANES; k++) begin
         r = $signed(quot_ff.q[k]) + (WORD_W+2)'(quot_ff.lo);
         if (!quot_ff.ranged) begin
            hash_in[k] = {1'b0, quot_ff.h[k]};
         end else if (r < hi_ext) begin
            hash_in[k] = r[HASH_W-1:0];
         end else begin
            hash_in[k] = hi_ext[HASH_W-1:0];
         end
      end
   end

   // Control: valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            if (advance[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Payload: hold while the stage is blocked
   always_ff @(posedge clock) begin
      for (int i = 0; i < MIX_STAGES; i++) begin
         if (advance[i]) begin
            mix_ff[i] <= mix_in[i];
         end
      end
      if (advance[PROD_IDX]) begin
         prod_ff <= prod_in;
      end
      if (advance[QUOT_IDX]) begin
         quot_ff <= quot_in;
      end
      if (advance[OUT_IDX]) begin
         hash_ff <= hash_in;
      end
   end

   assign rsp_tvalid = valid_ff[OUT_IDX];
   assign rsp_tdata  = {(RSP_DATA_W - LANES*HASH_W)'(0), hash_ff};

endmodule

[test/pcg4d_hash_checker.sv]
`timescale 1ns / 1ps
// Checker for the pcg4d hash range map block: predicts each rsp item from the
// req items it sees accepted and compares lane by lane. Depends on pcg4d_pkg.
module pcg4d_hash_checker
   import pcg4d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef logic [LANES-1:0][HASH_W-1:0] hash_set_type;

   hash_set_type pending_hashes[$];

   // min(hi, floor(span * h / 2^32) + lo) with span = hi - lo + 1, exact in 64 bits
   function automatic logic [HASH_W-1:0] map_to_range(input word_type h,
                                                       input logic signed [WORD_W-1:0] lo,
                                                       input logic signed [WORD_W-1:0] hi);
      longint          span;
      longint          quot;
      longint          mapped;
      longint unsigned prod;
      span = longint'(hi) - longint'(lo) + 1;
      if (span >= 0) begin
         prod = 64'(span) * 64'(h);
         quot = longint'(prod >> 32);
      end else begin
         // negative span: floor of a negative value rounds the magnitude up
         prod = 64'(-span) * 64'(h);
         quot = -longint'((prod >> 32) + 64'(prod[31:0] != 32'd0));
      end
      mapped = quot + longint'(lo);
      if (mapped > longint'(hi))
         mapped = longint'(hi);
      return mapped[HASH_W-1:0];
   endfunction

   function automatic hash_set_type predict_hash(input logic ranged,
                                                 input logic [REQ_DATA_W-1:0] data);
      word_type                 a, b, c, d;
      word_type                 h [LANES];
      logic signed [WORD_W-1:0] lo, hi;
      hash_set_type             result;
      a = data[0*WORD_W +: WORD_W] * LCG_MUL + LCG_ADD;
      b = data[1*WORD_W +: WORD_W] * LCG_MUL + LCG_ADD;
      c = data[2*WORD_W +: WORD_W] * LCG_MUL + LCG_ADD;
      d = data[3*WORD_W +: WORD_W] * LCG_MUL + LCG_ADD;
      lo = data[4*WORD_W +: WORD_W];
      hi = data[5*WORD_W +: WORD_W];
      a += b * d;
      b += c * a;
      c += a * b;
      d += b * c;
      a ^= a >> XS_SHIFT;
      b ^= b >> XS_SHIFT;
      c ^= c >> XS_SHIFT;
      d ^= d >> XS_SHIFT;
      a += b * d;
      b += c * a;
      c += a * b;
      d += b * c;
      h = '{a, b, c, d};
      for (int i = 0; i < LANES; i++)
         result[i] = ranged ? map_to_range(h[i], lo, hi) : {1'b0, h[i]};
      return result;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      hash_set_type want;
      hash_set_type got;
      int           bad;
      bad = 0;
      if (!reset) begin
         // retire before predicting so a stray rsp item never meets a fresh entry
         if (rsp_tvalid && rsp_tready) begin
            for (int i = 0; i < LANES; i++)
               got[i] = rsp_tdata[i*HASH_W +: HASH_W];
            if (pending_hashes.size() == 0) begin
               $display("%0t: rsp item with nothing pending: %h", $time, got);
               bad++;
            end else begin
               want = pending_hashes.pop_front();
               for (int i = 0; i < LANES; i++)
                  if (got[i] !== want[i]) begin
                     $display("%0t: rsp lane %0d expected %h actual %h",
                              $time, i, want[i], got[i]);
                     bad++;
                  end
            end
         end
         if (req_tvalid && req_tready)
            pending_hashes.push_back(predict_hash(req_tuser, req_tdata));
      end
      mismatches  <= mismatches + bad;
      outstanding <= pending_hashes.size();
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the pcg4d hash range map block: drives req items and rsp
// backpressure and gives the verdict. Depends on pcg4d_pkg and pcg4d_hash_checker.
module tb_top
   import pcg4d_pkg::*;
();

   // operation codes carried on req_tuser
   localparam logic OP_RAW    = 1'b0;
   localparam logic OP_RANGED = 1'b1;

   localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

   localparam int RANDOM_ITEMS = 800;
   localparam int HOLDOFF_LEN  = 120;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_RAW;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int mismatches;
   int outstanding;
   int holdoff_requests = 0;   // bumped by stimulus, served by the receiver
   int burst_left       = 0;

   always #4 clock = ~clock;

   pcg4d_hash_range_map_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pcg4d_hash_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Offer one coordinate tuple at a falling edge and hold it until accepted.
   // Valid stays high on return so back-to-back items form a burst.
   task automatic offer_tuple(input logic op,
                              input word_type x, input word_type y,
                              input word_type z, input word_type w,
                              input logic signed [WORD_W-1:0] lo,
                              input logic signed [WORD_W-1:0] hi);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {hi, lo, w, z, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Count down the current burst; at its end drop valid for a random gap.
   // Some bursts are long with no gap at all.
   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 5) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(40, 100);
         end else begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 5);
            burst_left = $urandom_range(1, 20);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   function automatic word_type pick_coord();
      case ($urandom_range(0, 11))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return word_type'($urandom_range(0, 255));
         default: return $urandom;
      endcase
   endfunction

   // Mostly random bounds, weighted toward the interesting range shapes:
   // upper-only, narrow, full width and inverted.
   task automatic offer_random_tuple();
      logic                     op;
      logic signed [WORD_W-1:0] lo, hi;
      op = ($urandom_range(0, 1) == 0) ? OP_RAW : OP_RANGED;
      lo = $urandom;
      hi = $urandom;
      case ($urandom_range(0, 9))
         4, 5: lo = '0;
         6, 7: hi = lo + $urandom_range(0, 300);
         8: begin
            lo = ($urandom_range(0, 1) == 0) ? S32_MIN : lo;
            hi = S32_MAX;
         end
         9: begin
            if ($urandom_range(0, 1) == 0) begin
               hi = lo - 1;
            end else begin
               lo = S32_MAX;
               hi = S32_MIN;
            end
         end
         default: ;
      endcase
      offer_tuple(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(), lo, hi);
   endtask

   // Receiver: pick a stall mode per window, and serve long hold-offs on request
   // so the pipeline fills and req_tready drops while the sender keeps offering.
   initial begin
      int mode;
      int window;
      int hold_left;
      int served;
      int phase;
      mode      = 0;
      window    = 0;
      hold_left = 0;
      served    = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (holdoff_requests != served) begin
            served    = holdoff_requests;
            hold_left = HOLDOFF_LEN;
         end
         if (window == 0) begin
            mode   = $urandom_range(0, 3);
            window = $urandom_range(16, 96);
         end
         window--;
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;                            // no stalls
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);     // light stalls
               2:       rsp_tready <= ($urandom_range(0, 9) < 3);      // heavy stalls
               default: rsp_tready <= (phase % 3 == 0);                // fixed pattern
            endcase
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: coordinate extremes in both modes, ranges ignored in raw mode
      offer_tuple(OP_RAW, '0, '0, '0, '0, '0, '0);
      pace_sender();
      offer_tuple(OP_RAW, '1, '1, '1, '1, S32_MIN, S32_MAX);
      pace_sender();
      offer_tuple(OP_RAW, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  S32_MAX, S32_MIN);
      pace_sender();
      offer_tuple(OP_RAW, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'sh1234_5678, -32'sd99);
      pace_sender();
      // single-value ranges
      offer_tuple(OP_RANGED, '0, '0, '0, '0, '0, '0);
      pace_sender();
      offer_tuple(OP_RANGED, '1, '1, '1, '1, S32_MIN, S32_MIN);
      pace_sender();
      offer_tuple(OP_RANGED, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1, 32'h2, S32_MAX, S32_MAX);
      pace_sender();
      // full range, span of 2^32
      offer_tuple(OP_RANGED, '0, '0, '0, '0, S32_MIN, S32_MAX);
      pace_sender();
      offer_tuple(OP_RANGED, '1, '1, '1, '1, S32_MIN, S32_MAX);
      pace_sender();
      offer_tuple(OP_RANGED, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  S32_MIN, S32_MAX);
      pace_sender();
      // upper-only form with lower bound zero
      offer_tuple(OP_RANGED, 32'd1, 32'd2, 32'd3, 32'd4, '0, S32_MAX);
      pace_sender();
      offer_tuple(OP_RANGED, 32'd7, 32'd8, 32'd9, 32'd10, '0, 32'sd99);
      pace_sender();
      // empty range: high one below low
      offer_tuple(OP_RANGED, 32'd11, 32'd12, 32'd13, 32'd14, '0, -32'sd1);
      pace_sender();
      offer_tuple(OP_RANGED, '1, '0, '1, '0, S32_MAX, S32_MAX - 1);
      pace_sender();
      // inverted ranges, down to the most negative span
      offer_tuple(OP_RANGED, 32'd21, 32'd22, 32'd23, 32'd24, S32_MAX, S32_MIN);
      pace_sender();
      offer_tuple(OP_RANGED, '1, '1, '1, '1, S32_MAX, S32_MIN);
      pace_sender();
      offer_tuple(OP_RANGED, 32'hDEAD_BEEF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
                  32'sd50, -32'sd50);
      pace_sender();
      // small symmetric, negative and positive ranges
      offer_tuple(OP_RANGED, 32'd31, 32'd32, 32'd33, 32'd34, -32'sd5, 32'sd5);
      pace_sender();
      offer_tuple(OP_RANGED, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  S32_MIN, S32_MIN + 1000);
      pace_sender();
      offer_tuple(OP_RANGED, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFF00_FF00, 32'h00FF_00FF,
                  S32_MAX - 1000, S32_MAX);
      pace_sender();

      // Random part; ask the receiver for two long hold-offs along the way
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 250 || n == 550)
            holdoff_requests++;
         offer_random_tuple();
         pace_sender();
      end
      req_tvalid <= 1'b0;

      // Drain: wait until no predicted item is outstanding, then give the verdict
      while (outstanding != 0) @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[files.f]
src/pcg4d_pkg.sv
src/pcg4d_hash_range_map_top.sv
test/pcg4d_hash_checker.sv
test/tb_top.sv
